[design/bounded_ordered_list_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the bounded ordered list unit
// Wraps the clocking, the reset qualifier and the error report of a property.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_ORDERED_LIST_UNIT_ASSERT_SVH
`define BOUNDED_ORDERED_LIST_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BOL_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BOL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/bol_pkg.sv]
// ----------------------------------------------------------------------------
// bol_pkg
// Sizes, command and status codes and the cell control bundle of the list.
// ----------------------------------------------------------------------------
package bol_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Fixed field widths of the ports.
  localparam int CMD_W  = 3;
  localparam int POS_W  = 6;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int FPOS_W = 5;
  localparam int OCNT_W = 5;

  // Width used to compare a position against the count.
  localparam int CMP_W  = (POS_W > CNT_W) ? POS_W : CNT_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND      = 3'd0,
    CMD_INSERT_AT   = 3'd1,
    CMD_REMOVE_LAST = 3'd2,
    CMD_REMOVE_AT   = 3'd3,
    CMD_INDEX_OF    = 3'd4
  } bol_cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_IGNORED = 2'd2
  } bol_status_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } bol_op_t;

  // Broadcast to every cell in the row.
  typedef struct packed {
    bol_op_t          op;
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] count;
    logic [VAL_W-1:0] value;
  } cell_ctrl_t;

endpackage

[design/bol_cell.sv]
// ----------------------------------------------------------------------------
// bol_cell
// One list entry: shifts with its neighbours on insert and remove, and
// compares its stored value against the broadcast search value.
// ----------------------------------------------------------------------------
module bol_cell (
  input  logic                          clk,
  input  bol_pkg::cell_ctrl_t           ctrl,
  input  logic [bol_pkg::IDX_W-1:0]     cell_idx,
  input  logic [bol_pkg::VAL_W-1:0]     left_data,
  input  logic [bol_pkg::VAL_W-1:0]     right_data,
  output logic [bol_pkg::VAL_W-1:0]     data,
  output logic                          hit
);
  import bol_pkg::*;

  logic [VAL_W-1:0] data_r;
  logic [VAL_W-1:0] data_nxt;
  logic [CNT_W-1:0] idx_c;

  assign idx_c = CNT_W'(cell_idx);

  always_comb begin
    data_nxt = data_r;
    case (ctrl.op)
      OP_INSERT: begin
        if (idx_c > ctrl.pos) begin
          data_nxt = left_data;
        end else if (idx_c == ctrl.pos) begin
          data_nxt = ctrl.value;
        end
      end
      OP_REMOVE: begin
        if (idx_c >= ctrl.pos) begin
          data_nxt = right_data;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;
  // Only occupied entries may match.
  assign hit  = (idx_c < ctrl.count) && (data_r == ctrl.value);

endmodule

[design/bounded_ordered_list_unit.sv]
// The result is captured in the output register in the cycle after the input transfer.
// Throughput: one command per cycle; every cell shifts and compares in parallel.
// A new command is taken whenever the output register is empty or being drained.
// Reset (rst_n, synchronous, active low) empties the list and the output register.
// ----------------------------------------------------------------------------
// bounded_ordered_list_unit
// Ordered list of signed 32-bit values held in a row of register cells, with
// append, insert-at, remove-last, remove-at and index-of commands.
// ----------------------------------------------------------------------------
module bounded_ordered_list_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [bol_pkg::CMD_W-1:0]      in_cmd,
  input  logic [bol_pkg::POS_W-1:0]      in_position,
  input  logic signed [bol_pkg::VAL_W-1:0] in_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bol_pkg::STAT_W-1:0]     out_status,
  output logic                           out_found,
  output logic [bol_pkg::FPOS_W-1:0]     out_found_position,
  output logic [bol_pkg::OCNT_W-1:0]     out_count
);
  import bol_pkg::*;

  `include "bounded_ordered_list_unit_assert.svh"

  // Control state: the entry count and the output register's valid flag.
  logic             out_valid_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  // Result payload register.
  bol_status_t      status_r;
  bol_status_t      status_nxt;
  logic             found_r;
  logic [CNT_W-1:0] fpos_r;
  logic [CNT_W-1:0] cnt_out_r;

  logic             in_xfer;
  logic             full;
  logic             in_range;
  logic [CNT_W-1:0] ins_pos;
  logic             srch_found;
  logic [CNT_W-1:0] srch_fpos;
  cell_ctrl_t       ctrl;

  logic [VAL_W-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0] cell_hit;

  // The output register parts the two channels: a command is taken while the
  // previous result is being collected.
  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign in_range = (CMP_W'(in_position) < CMP_W'(cnt_r));
  // An insert position past the end turns into an append.
  assign ins_pos  = in_range ? CNT_W'(in_position) : cnt_r;

  // Command decode: the broadcast to the cells, the new count and the status.
  always_comb begin
    ctrl.op    = OP_HOLD;
    ctrl.pos   = cnt_r;
    ctrl.count = cnt_r;
    ctrl.value = in_value;
    cnt_nxt    = cnt_r;
    status_nxt = ST_DONE;
    unique case (bol_cmd_t'(in_cmd))
      CMD_APPEND: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          ctrl.op  = OP_INSERT;
          ctrl.pos = cnt_r;
          cnt_nxt  = cnt_r + CNT_W'(1);
        end
      end
      CMD_INSERT_AT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          ctrl.op  = OP_INSERT;
          ctrl.pos = ins_pos;
          cnt_nxt  = cnt_r + CNT_W'(1);
        end
      end
      CMD_REMOVE_LAST: begin
        if (cnt_r == '0) begin
          status_nxt = ST_IGNORED;
        end else begin
          ctrl.op  = OP_REMOVE;
          ctrl.pos = cnt_r - CNT_W'(1);
          cnt_nxt  = cnt_r - CNT_W'(1);
        end
      end
      CMD_REMOVE_AT: begin
        if (!in_range) begin
          status_nxt = ST_IGNORED;
        end else begin
          ctrl.op  = OP_REMOVE;
          ctrl.pos = CNT_W'(in_position);
          cnt_nxt  = cnt_r - CNT_W'(1);
        end
      end
      default: ;
    endcase
    // The cells change only on an accepted command.
    if (!in_xfer) begin
      ctrl.op = OP_HOLD;
    end
  end

  // Row of cells. Each takes its left neighbour's value when an insert opens
  // a gap below it and its right neighbour's value when a removal closes one.
  // The row ends are fed with zero; those values never become visible
  // because they land only beyond the occupied range.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [VAL_W-1:0] left_in;
    logic [VAL_W-1:0] right_in;

    if (g == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_mid_l
      assign left_in = cell_data[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_mid_r
      assign right_in = cell_data[g+1];
    end

    bol_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .cell_idx   (IDX_W'(g)),
      .left_data  (left_in),
      .right_data (right_in),
      .data       (cell_data[g]),
      .hit        (cell_hit[g])
    );
  end

  // First match wins: scanning from the top lets the lowest hit overwrite.
  always_comb begin
    srch_found = 1'b0;
    srch_fpos  = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (cell_hit[i]) begin
        srch_found = 1'b1;
        srch_fpos  = CNT_W'(i + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (in_xfer) begin
        out_valid_r <= 1'b1;
        cnt_r       <= cnt_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // The search reads the cells before this command's update; index-of never
  // changes them, so the result matches the list it was issued against.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      status_r  <= status_nxt;
      found_r   <= (bol_cmd_t'(in_cmd) == CMD_INDEX_OF) && srch_found;
      fpos_r    <= (bol_cmd_t'(in_cmd) == CMD_INDEX_OF) ? srch_fpos : '0;
      cnt_out_r <= cnt_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_found          = found_r;
  assign out_found_position = FPOS_W'(fpos_r);
  assign out_count          = OCNT_W'(cnt_out_r);

  // The count never passes the capacity.
  `BOL_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(DEPTH), "entry count above capacity")
  // A reported match always carries a non-zero position, and only then.
  `BOL_ASSERT_SAME(a_found_pos, out_valid_r, out_found == (fpos_r != '0), "found flag and position disagree")
  // An insert into a full list leaves the count and flags the drop.
  `BOL_ASSERT_NEXT(a_full_drop, in_xfer && full && (in_cmd == CMD_APPEND || in_cmd == CMD_INSERT_AT), status_r == ST_FULL && cnt_r == $past(cnt_r), "insert into full list not dropped")
  // A stalled result may not be replaced by a new command.
  `BOL_ASSERT_SAME(a_no_overrun, out_valid_r && !out_ready, !in_xfer, "result overwritten while stalled")

endmodule
